// ===== design/playfair_cipher_core_defines.svh =====
// Assertion macros shared by the Playfair cipher core RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PLAYFAIR_CIPHER_CORE_DEFINES_SVH
`define PLAYFAIR_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pfc_pkg.sv =====
// Shared types, constants and helper functions for the Playfair cipher core.
// No dependencies; imported by the interfaces and the top level.
package pfc_pkg;

  localparam int CHAR_IN_W  = 8;
  localparam int CHAR_OUT_W = 7;
  localparam int LETTER_W   = 5;
  localparam int SIDE_W     = 3;
  localparam int LETTERS    = 26;
  localparam int CELLS      = 25;

  localparam logic [LETTER_W-1:0] CELL_COUNT    = 5'd25;
  localparam logic [LETTER_W-1:0] LETTER_I      = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J      = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_Z      = 5'd25;
  localparam logic [LETTER_W-1:0] FILLER_RESET  = 5'd23;
  localparam logic [SIDE_W-1:0]   SIDE_LAST     = 3'd4;

  localparam logic [CHAR_IN_W-1:0]  ASCII_UP_A  = 8'h41;
  localparam logic [CHAR_IN_W-1:0]  ASCII_UP_Z  = 8'h5A;
  localparam logic [CHAR_IN_W-1:0]  ASCII_LO_A  = 8'h61;
  localparam logic [CHAR_IN_W-1:0]  ASCII_LO_Z  = 8'h7A;
  localparam logic [CHAR_OUT_W-1:0] ASCII_OUT_A = 7'h41;

  // Request opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DECRYPT = 1'b0;
  localparam logic CFG_FILLER  = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  // Map a raw byte to an alphabet index, J folded onto I
  function automatic letter_t norm_letter(input logic [CHAR_IN_W-1:0] ch);
    letter_t             r;
    logic [CHAR_IN_W-1:0] d;
    r.valid = 1'b0;
    d       = '0;
    if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
      d       = ch - ASCII_UP_A;
      r.valid = 1'b1;
    end else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
      d       = ch - ASCII_LO_A;
      r.valid = 1'b1;
    end
    r.idx = d[LETTER_W-1:0];
    if (r.idx == LETTER_J) r.idx = LETTER_I;
    return r;
  endfunction

  // Clamp the filler to Z and fold J onto I
  function automatic logic [LETTER_W-1:0] pad_letter(input logic [LETTER_W-1:0] f);
    logic [LETTER_W-1:0] p;
    p = (f > LETTER_Z) ? LETTER_Z : f;
    if (p == LETTER_J) p = LETTER_I;
    return p;
  endfunction

  // Row of a cell index, by compare against row starts
  function automatic logic [SIDE_W-1:0] cell_row(input logic [LETTER_W-1:0] c);
    logic [SIDE_W-1:0] r;
    if (c >= 5'd20)      r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // Cell index from row and column: row*5 + col
  function automatic logic [LETTER_W-1:0] cell_at(input logic [SIDE_W-1:0] r,
                                                  input logic [SIDE_W-1:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // Column of a cell index
  function automatic logic [SIDE_W-1:0] cell_col(input logic [LETTER_W-1:0] c);
    logic [LETTER_W-1:0] diff;
    diff = c - cell_at(cell_row(c), 3'd0);
    return diff[SIDE_W-1:0];
  endfunction

  // Move one place along a row or column, wrapping at the edge
  function automatic logic [SIDE_W-1:0] step5(input logic [SIDE_W-1:0] v, input logic dec);
    logic [SIDE_W-1:0] s;
    if (dec) s = (v == 3'd0) ? SIDE_LAST : v - 3'd1;
    else     s = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    return s;
  endfunction

  // ASCII uppercase letter of an alphabet index
  function automatic logic [CHAR_OUT_W-1:0] letter_char(input logic [LETTER_W-1:0] l);
    logic [LETTER_W-1:0] c;
    c = (l > LETTER_Z) ? LETTER_Z : l;
    return ASCII_OUT_A + {2'b00, c};
  endfunction

endpackage

// ===== design/pfc_in_if.sv =====
// Input request channel of the Playfair cipher core: valid/ready plus payload.
// Depends on pfc_pkg for field widths.
interface pfc_in_if import pfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [CHAR_IN_W-1:0] char_in;
  logic                 last_in;

  modport source (output valid, opcode, char_in, last_in, input ready);
  modport sink   (input valid, opcode, char_in, last_in, output ready);
endinterface

// ===== design/pfc_out_if.sv =====
// Result channel of the Playfair cipher core: valid/ready plus payload.
// Depends on pfc_pkg for field widths.
interface pfc_out_if import pfc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHAR_OUT_W-1:0] char_out;
  logic                  last_out;

  modport source (output valid, char_out, last_out, input ready);
  modport sink   (input valid, char_out, last_out, output ready);
endinterface

// ===== design/pfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== design/playfair_cipher_core.sv =====
// Playfair cipher core: one key or text byte per request, one letter per result.
// Key byte: placed when taken; the last one starts a walk that fills the square.
// Text byte: per digraph (up to two): S_LA, S_LB, S_CALC, S_SQ1, S_OUT1, S_OUT2,
// as each RAM has one read port; new requests wait for idle, letters for ready.
// Reset (rst_n low, synchronous) clears the key, the pending letter and the
// registers (encrypt, filler X); the square RAMs are not cleared.
`include "playfair_cipher_core_defines.svh"

module playfair_cipher_core import pfc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [LETTER_W-1:0] cfg_wdata,
  pfc_in_if.sink              in_if,
  pfc_out_if.source           out_if
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_LA   = 8'b0000_0100,
    S_LB   = 8'b0000_1000,
    S_CALC = 8'b0001_0000,
    S_SQ1  = 8'b0010_0000,
    S_OUT1 = 8'b0100_0000,
    S_OUT2 = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                  decrypt_r;
  logic [LETTER_W-1:0]   filler_r;
  logic [LETTER_W-1:0]   k_r, k_nxt;
  logic [LETTERS-1:0]    used_r, used_nxt, used_base;
  logic [LETTER_W-1:0]   fill_r, fill_nxt, fill_base;
  logic                  complete_r, complete_nxt;
  logic [LETTER_W-1:0]   held_r, held_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic [LETTER_W-1:0]   cur_a_r, cur_a_nxt, cur_b_r, cur_b_nxt;
  logic                  cur_last_r, cur_last_nxt;
  logic                  q_valid_r, q_valid_nxt;
  logic [LETTER_W-1:0]   q_a_r, q_a_nxt, q_b_r, q_b_nxt;
  logic [LETTER_W-1:0]   pa_r, pa_nxt;
  logic [LETTER_W-1:0]   cell1_r, cell1_nxt, cell2_r, cell2_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_OUT_W-1:0] out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                accept, slot_free;
  letter_t             in_norm;
  logic [LETTER_W-1:0] pad;
  logic [LETTER_W-1:0] place_letter;
  logic                place_req, place_en;
  logic                d1, d2, hv;
  logic [LETTER_W-1:0] b1, hl;
  logic [SIDE_W-1:0]   r1, c1, r2, c2;

  logic                lc_re, ks_re;
  logic [LETTER_W-1:0] lc_raddr, ks_raddr;
  logic [LETTER_W-1:0] lc_rdata, ks_rdata;

  assign accept    = in_if.valid && in_if.ready;
  assign slot_free = !out_valid_r || out_if.ready;
  assign in_norm   = norm_letter(in_if.char_in);
  assign pad       = pad_letter(filler_r);

  assign in_if.ready     = (state_r == S_IDLE);
  assign out_if.valid    = out_valid_r;
  assign out_if.char_out = out_char_r;
  assign out_if.last_out = out_last_r;

  // Placement unit: shared by key bytes and the fill walk
  assign used_base    = complete_r ? '0 : used_r;
  assign fill_base    = complete_r ? '0 : fill_r;
  assign place_letter = (state_r == S_FILL) ? k_r : in_norm.idx;
  assign place_req    = (state_r == S_FILL) ? (k_r != LETTER_J)
                      : (accept && in_if.opcode == OP_KEY && in_norm.valid);
  assign place_en     = place_req && !used_base[place_letter] && (fill_base < CELL_COUNT);

  // Pair forming for a text request
  always_comb begin
    d1 = 1'b0;
    b1 = in_norm.idx;
    hl = held_r;
    hv = held_valid_r;
    if (in_norm.valid) begin
      if (!held_valid_r) begin
        hl = in_norm.idx;
        hv = 1'b1;
      end else if (!decrypt_r && held_r == in_norm.idx) begin
        d1 = 1'b1;
        b1 = pad;
      end else begin
        d1 = 1'b1;
        hv = 1'b0;
      end
    end
    d2 = in_if.last_in && hv;
    if (in_if.last_in) hv = 1'b0;
  end

  // Row and column of both letters of the current digraph
  assign r1 = cell_row(pa_r);
  assign c1 = cell_col(pa_r);
  assign r2 = cell_row(lc_rdata);
  assign c2 = cell_col(lc_rdata);

  // Sequencer and next-state logic
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    used_nxt       = used_r;
    fill_nxt       = fill_r;
    complete_nxt   = complete_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    cur_a_nxt      = cur_a_r;
    cur_b_nxt      = cur_b_r;
    cur_last_nxt   = cur_last_r;
    q_valid_nxt    = q_valid_r;
    q_a_nxt        = q_a_r;
    q_b_nxt        = q_b_r;
    pa_nxt         = pa_r;
    cell1_nxt      = cell1_r;
    cell2_nxt      = cell2_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    lc_re          = 1'b0;
    lc_raddr       = cur_a_r;
    ks_re          = 1'b0;
    ks_raddr       = cell1_r;

    // Fold a placement into the letter set and fill count
    if (state_r == S_FILL || (accept && in_if.opcode == OP_KEY)) begin
      used_nxt = used_base;
      if (place_en) used_nxt[place_letter] = 1'b1;
      fill_nxt = fill_base + {{(LETTER_W-1){1'b0}}, place_en};
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_if.opcode == OP_KEY) begin
          complete_nxt = 1'b0;
          if (in_if.last_in) begin
            k_nxt     = '0;
            state_nxt = S_FILL;
          end
        end else if (accept) begin
          held_nxt       = hl;
          held_valid_nxt = hv;
          q_valid_nxt    = 1'b0;
          if (d1) begin
            cur_a_nxt    = held_r;
            cur_b_nxt    = b1;
            cur_last_nxt = in_if.last_in && !d2;
            q_valid_nxt  = d2;
            q_a_nxt      = hl;
            q_b_nxt      = pad;
            state_nxt    = S_LA;
          end else if (d2) begin
            cur_a_nxt    = hl;
            cur_b_nxt    = pad;
            cur_last_nxt = 1'b1;
            state_nxt    = S_LA;
          end
        end
      end
      S_FILL: begin
        k_nxt = k_r + 5'd1;
        if (k_r == LETTER_Z) begin
          complete_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LA: begin
        lc_re     = 1'b1;
        lc_raddr  = cur_a_r;
        state_nxt = S_LB;
      end
      S_LB: begin
        lc_re     = 1'b1;
        lc_raddr  = cur_b_r;
        pa_nxt    = lc_rdata;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (r1 == r2) begin
          cell1_nxt = cell_at(r1, step5(c1, decrypt_r));
          cell2_nxt = cell_at(r2, step5(c2, decrypt_r));
        end else if (c1 == c2) begin
          cell1_nxt = cell_at(step5(r1, decrypt_r), c1);
          cell2_nxt = cell_at(step5(r2, decrypt_r), c2);
        end else begin
          cell1_nxt = cell_at(r1, c2);
          cell2_nxt = cell_at(r2, c1);
        end
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        ks_re     = 1'b1;
        ks_raddr  = cell1_r;
        state_nxt = S_OUT1;
      end
      S_OUT1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = letter_char(ks_rdata);
          out_last_nxt  = 1'b0;
          ks_re         = 1'b1;
          ks_raddr      = cell2_r;
          state_nxt     = S_OUT2;
        end
      end
      S_OUT2: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = letter_char(ks_rdata);
          out_last_nxt  = cur_last_r;
          if (q_valid_r) begin
            cur_a_nxt    = q_a_r;
            cur_b_nxt    = q_b_r;
            cur_last_nxt = 1'b1;
            q_valid_nxt  = 1'b0;
            state_nxt    = S_LA;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      used_r       <= '0;
      fill_r       <= '0;
      complete_r   <= 1'b0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      q_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      decrypt_r    <= 1'b0;
      filler_r     <= FILLER_RESET;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      used_r       <= used_nxt;
      fill_r       <= fill_nxt;
      complete_r   <= complete_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      q_valid_r    <= q_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DECRYPT: decrypt_r <= cfg_wdata[0];
          CFG_FILLER:  filler_r  <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_a_r    <= cur_a_nxt;
    cur_b_r    <= cur_b_nxt;
    cur_last_r <= cur_last_nxt;
    q_a_r      <= q_a_nxt;
    q_b_r      <= q_b_nxt;
    pa_r       <= pa_nxt;
    cell1_r    <= cell1_nxt;
    cell2_r    <= cell2_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Cell index per letter
  pfc_ram #(
    .DATA_W (LETTER_W),
    .DEPTH  (LETTERS)
  ) u_letter_cell (
    .clk   (clk),
    .we    (place_en),
    .waddr (place_letter),
    .wdata (fill_base),
    .re    (lc_re),
    .raddr (lc_raddr),
    .rdata (lc_rdata)
  );

  // Letter per cell of the key square
  pfc_ram #(
    .DATA_W (LETTER_W),
    .DEPTH  (CELLS)
  ) u_key_square (
    .clk   (clk),
    .we    (place_en),
    .waddr (fill_base),
    .wdata (place_letter),
    .re    (ks_re),
    .raddr (ks_raddr),
    .rdata (ks_rdata)
  );

  // Checks on sequencer and key fill
  `PFC_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CELL_COUNT, "square fill past 25 cells")
  `PFC_ASSERT_NOW(a_key_full, $rose(complete_r), fill_r == CELL_COUNT, "key done with square not full")
  `PFC_ASSERT_NOW(a_queue_busy, q_valid_r, state_r != S_IDLE, "queued digraph left while idle")
  `PFC_ASSERT_NEXT(a_last_ends, state_r == S_OUT2 && slot_free && cur_last_r, state_r == S_IDLE && !q_valid_r, "work left after final letter")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Playfair cipher core: queued key and text requests,
// a built-in predictor of the cipher, random stalls on both channels.
// Depends on pfc_pkg, pfc_in_if and pfc_out_if from the design folder.
module testbench;
  import pfc_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_STALL   = 300;
  localparam int SEGMENTS     = 6;
  localparam int SEG_REQS     = 30;

  typedef struct packed {
    logic                 op;
    logic [CHAR_IN_W-1:0] ch;
    logic                 last;
  } text_req_t;

  typedef struct packed {
    logic [CHAR_OUT_W-1:0] ch;
    logic                  last;
  } cipher_letter_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [LETTER_W-1:0] cfg_wdata;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  playfair_cipher_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  // Request and result stores
  text_req_t      pending_reqs[$];
  cipher_letter_t expected_letters[$];

  int  send_idle_pct = 35;
  int  recv_idle_pct = 45;
  logic long_stall_req = 1'b0;
  int  stall_count = 0;
  int  mismatches = 0;
  int  cycle_count = 0;

  // Cipher state mirrored from the block
  logic [LETTER_W-1:0] square_letter [0:CELLS-1];
  logic [LETTER_W-1:0] cell_of [0:LETTERS-1];
  logic [LETTERS-1:0]  used_set = '0;
  int                  fill_count = 0;
  logic                key_done = 1'b0;
  logic [LETTER_W-1:0] held = '0;
  logic                held_v = 1'b0;
  logic                dec_mode = 1'b0;
  logic [LETTER_W-1:0] filler_reg = FILLER_RESET;

  initial begin
    for (int i = 0; i < CELLS; i++) square_letter[i] = '0;
    for (int i = 0; i < LETTERS; i++) cell_of[i] = '0;
  end

  // Alphabet index of a raw byte, J folded onto I; -1 for a non-letter
  function automatic int letter_of(input logic [CHAR_IN_W-1:0] ch);
    int v;
    if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) v = int'(ch - ASCII_UP_A);
    else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) v = int'(ch - ASCII_LO_A);
    else return -1;
    if (v == LETTER_J) v = LETTER_I;
    return v;
  endfunction

  function automatic logic [LETTER_W-1:0] padding_letter();
    logic [LETTER_W-1:0] p;
    p = (filler_reg > LETTER_Z) ? LETTER_Z : filler_reg;
    if (p == LETTER_J) p = LETTER_I;
    return p;
  endfunction

  function automatic void place_letter(input int l);
    if (fill_count >= CELLS || used_set[l]) return;
    square_letter[fill_count] = l[LETTER_W-1:0];
    cell_of[l] = fill_count[LETTER_W-1:0];
    used_set[l] = 1'b1;
    fill_count++;
  endfunction

  // Transform one digraph on the current square: {first, second}
  function automatic logic [2*LETTER_W-1:0] cipher_pair(input logic [LETTER_W-1:0] a,
                                                         input logic [LETTER_W-1:0] b);
    int pa, pb, r1, c1, r2, c2, d;
    logic [LETTER_W-1:0] x, y;
    pa = cell_of[a] % CELLS;
    pb = cell_of[b] % CELLS;
    r1 = pa / 5; c1 = pa % 5;
    r2 = pb / 5; c2 = pb % 5;
    d  = dec_mode ? 4 : 1;
    if (r1 == r2) begin
      x = square_letter[r1 * 5 + (c1 + d) % 5];
      y = square_letter[r2 * 5 + (c2 + d) % 5];
    end else if (c1 == c2) begin
      x = square_letter[((r1 + d) % 5) * 5 + c1];
      y = square_letter[((r2 + d) % 5) * 5 + c2];
    end else begin
      x = square_letter[r1 * 5 + c2];
      y = square_letter[r2 * 5 + c1];
    end
    return {x, y};
  endfunction

  // Advance the mirrored cipher by one accepted request and queue its letters
  function automatic void cipher_step(input text_req_t req);
    int l;
    int n;
    logic [LETTER_W-1:0] outs [4];
    logic [2*LETTER_W-1:0] p;
    cipher_letter_t e;
    l = letter_of(req.ch);
    n = 0;
    if (req.op == OP_KEY) begin
      if (key_done) begin
        used_set = '0;
        fill_count = 0;
        key_done = 1'b0;
      end
      if (l >= 0) place_letter(l);
      if (req.last) begin
        for (int k = 0; k < LETTERS; k++)
          if (k != LETTER_J) place_letter(k);
        key_done = 1'b1;
      end
      return;
    end
    if (l >= 0) begin
      if (!held_v) begin
        held = l[LETTER_W-1:0];
        held_v = 1'b1;
      end else if (!dec_mode && held == l[LETTER_W-1:0]) begin
        p = cipher_pair(held, padding_letter());
        outs[n] = p[2*LETTER_W-1:LETTER_W]; outs[n+1] = p[LETTER_W-1:0]; n += 2;
      end else begin
        p = cipher_pair(held, l[LETTER_W-1:0]);
        outs[n] = p[2*LETTER_W-1:LETTER_W]; outs[n+1] = p[LETTER_W-1:0]; n += 2;
        held_v = 1'b0;
      end
    end
    if (req.last) begin
      if (held_v) begin
        p = cipher_pair(held, padding_letter());
        outs[n] = p[2*LETTER_W-1:LETTER_W]; outs[n+1] = p[LETTER_W-1:0]; n += 2;
      end
      held_v = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      e.ch   = ASCII_OUT_A + {2'b00, outs[i]};
      e.last = req.last && (i == n - 1);
      expected_letters.push_back(e);
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: hold a request until accepted, then load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        cipher_step('{op: in_if.opcode, ch: in_if.char_in, last: in_if.last_in});
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          text_req_t r;
          r = pending_reqs.pop_front();
          in_if.valid   <= 1'b1;
          in_if.opcode  <= r.op;
          in_if.char_in <= r.ch;
          in_if.last_in <= r.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_stall_req && stall_count < LONG_STALL) begin
      stall_count  <= stall_count + 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each accepted letter with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_letters.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected letter %c last=%0b", out_if.char_out, out_if.last_out);
      end else begin
        cipher_letter_t e;
        e = expected_letters.pop_front();
        if (out_if.char_out !== e.ch || out_if.last_out !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %c last=%0b, got %c last=%0b",
                     e.ch, e.last, out_if.char_out, out_if.last_out);
        end
      end
    end
  end

  task automatic push_req(input logic op, input logic [CHAR_IN_W-1:0] ch, input logic last);
    pending_reqs.push_back('{op: op, ch: ch, last: last});
  endtask

  task automatic push_string(input logic op, input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++)
      push_req(op, s[i], end_last && (i == s.len() - 1));
  endtask

  // Wait for every request and result, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_letters.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LETTER_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DECRYPT) dec_mode = val[0];
    else filler_reg = val;
  endtask

  function automatic logic [CHAR_IN_W-1:0] random_letter();
    logic [CHAR_IN_W-1:0] base;
    base = $urandom_range(0, 1) ? ASCII_UP_A : ASCII_LO_A;
    return base + 8'($urandom_range(0, 25));
  endfunction

  // Random key: a few bytes, mostly letters, closed by a last-marked byte
  task automatic add_key();
    int len;
    len = $urandom_range(0, 14);
    for (int i = 0; i < len; i++)
      push_req(OP_KEY, ($urandom_range(0, 99) < 80) ? random_letter()
                                                     : 8'($urandom_range(0, 255)), 1'b0);
    push_req(OP_KEY, ($urandom_range(0, 1) != 0) ? random_letter()
                                                  : 8'($urandom_range(0, 255)),
             1'b1);
  endtask

  // Random message with repeats, filler letters and noise; some are left open
  task automatic add_message(input logic [LETTER_W-1:0] fl);
    int len, r;
    logic [CHAR_IN_W-1:0] ch, prev;
    logic open;
    len  = $urandom_range(1, 10);
    open = ($urandom_range(0, 99) < 15);
    prev = ASCII_UP_A;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15 && i > 0) ch = prev;
      else if (r < 25) ch = ASCII_UP_A + ((fl > LETTER_Z) ? LETTER_Z : fl);
      else if (r < 82) ch = random_letter();
      else ch = 8'($urandom_range(0, 255));
      push_req(OP_TEXT, ch, !open && (i == len - 1));
      prev = ch;
    end
  endtask

  // Stimulus sequence
  initial begin
    logic                dec_set  [SEGMENTS];
    logic [LETTER_W-1:0] fill_set [SEGMENTS];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DECRYPT;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.opcode  = OP_KEY;
    in_if.char_in = '0;
    in_if.last_in = 1'b0;
    out_if.ready  = 1'b0;
    dec_set  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    fill_set = '{5'd23, 5'd0, 5'd25, LETTER_J, 5'd31, 5'd0};
    fill_set[5] = 5'($urandom_range(0, 25));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key with lower case, J and a non-letter last byte
    push_string(OP_KEY, "MonarchJy", 1'b0);
    push_req(OP_KEY, 8'h21, 1'b1);
    // Split doubled letters, fold J, pad an odd tail on a non-letter last byte
    push_string(OP_TEXT, "baLlxxJi", 1'b0);
    push_req(OP_TEXT, 8'h7B, 1'b1);
    // Extreme bytes are ignored; a last byte with nothing pending gives nothing
    push_req(OP_TEXT, 8'h00, 1'b0);
    push_req(OP_TEXT, 8'hFF, 1'b0);
    push_req(OP_TEXT, 8'h23, 1'b1);
    // A new key keeps the pending text letter
    push_req(OP_TEXT, "Q", 1'b0);
    push_req(OP_KEY, "z", 1'b1);
    push_req(OP_TEXT, "k", 1'b1);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      send_idle_pct <= (seg < 2) ? 35 : (seg < 4) ? 45 : 0;
      recv_idle_pct <= (seg < 2) ? 45 : (seg < 4) ? 35 : 0;
      write_reg(CFG_DECRYPT, {4'($urandom_range(0, 15)), dec_set[seg]});
      write_reg(CFG_FILLER, fill_set[seg]);
      if (seg == 0) add_key();
      while (pending_reqs.size() < SEG_REQS) begin
        if ($urandom_range(0, 3) == 0) add_key();
        else add_message(fill_set[seg]);
      end
      // Close any open message so the segment drains fully
      push_req(OP_TEXT, 8'h2E, 1'b1);
      if (seg == 4) long_stall_req <= 1'b1;
    end

    wait_idle();
    if (mismatches == 0 && expected_letters.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/pfc_pkg.sv
design/pfc_in_if.sv
design/pfc_out_if.sv
design/pfc_ram.sv
design/playfair_cipher_core.sv
tb/sv/testbench.sv
